[design/transition_easing_progress_core_assert.svh]
// assertion macros used by the checker file of the easing core
// expects signals clk and rst_n in the scope of use
`ifndef TRANSITION_EASING_PROGRESS_CORE_ASSERT_SVH
`define TRANSITION_EASING_PROGRESS_CORE_ASSERT_SVH

// same-cycle implication under reset
`define TEP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tep assertion failed");

// next-cycle implication under reset
`define TEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tep assertion failed");

`endif

[design/tep_pkg.sv]
// shared types and constants of the transition easing core
// no dependencies
package tep_pkg;

    localparam int DUR_W  = 24;
    localparam int KIND_W = 3;
    localparam int ELAP_W = 32;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FADE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MORPH  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SLIDE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WIPE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BLINK  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RANDOM = 3'd6;

    localparam logic [0:0] REG_KIND     = 1'b0;
    localparam logic [0:0] REG_DURATION = 1'b1;

    localparam logic [DUR_W-1:0] DURATION_RESET = 24'd1000;

    // operations handed from front to back
    localparam logic [2:0] OP_NEG   = 3'd0;
    localparam logic [2:0] OP_ONE   = 3'd1;
    localparam logic [2:0] OP_ZERO  = 3'd2;
    localparam logic [2:0] OP_LIN   = 3'd3;
    localparam logic [2:0] OP_CUBIC = 3'd4;

    localparam logic [15:0] HASH_SEED = 16'h79b9;
    localparam logic [15:0] HASH_MUL  = 16'h4e6d;
    localparam logic [15:0] HASH_ADD  = 16'h3039;
    localparam logic [DUR_W-1:0] RAND_DIV = 24'd65535;

    typedef struct packed {
        logic [2:0]       op;
        logic [DUR_W-1:0] num;
        logic [DUR_W-1:0] den;
    } entry_t;

endpackage

[design/tep_front.sv]
// front end: classifies an elapsed time into a queue entry
// depends on tep_pkg
module tep_front
(
    input  logic [tep_pkg::ELAP_W-1:0] elapsed_ms,
    input  logic [tep_pkg::KIND_W-1:0] kind,
    input  logic [tep_pkg::DUR_W-1:0]  duration,
    output tep_pkg::entry_t            entry
);

    logic [30:0] e;
    logic [31:0] hprod;
    logic [15:0] r;

    assign e     = elapsed_ms[30:0];
    assign hprod = (elapsed_ms[15:0] ^ tep_pkg::HASH_SEED) * tep_pkg::HASH_MUL;
    assign r     = hprod[15:0] + tep_pkg::HASH_ADD;

    always_comb
    begin
        entry.op  = tep_pkg::OP_LIN;
        entry.num = e[tep_pkg::DUR_W-1:0];
        entry.den = duration;
        if (elapsed_ms[31])
        begin
            entry.op = tep_pkg::OP_NEG;
        end
        else if (kind == tep_pkg::KIND_NONE || duration == '0 ||
                 e >= {7'd0, duration})
        begin
            entry.op = tep_pkg::OP_ONE;
        end
        else
        begin
            case (kind)
                tep_pkg::KIND_SLIDE, tep_pkg::KIND_WIPE:
                    entry.op = tep_pkg::OP_CUBIC;
                tep_pkg::KIND_BLINK:
                    entry.op = ({1'b0, e, 1'b0} < {9'd0, duration}) ?
                               tep_pkg::OP_ONE : tep_pkg::OP_ZERO;
                tep_pkg::KIND_RANDOM:
                begin
                    // full-scale hash maps exactly to one
                    if (r == 16'hffff)
                        entry.op = tep_pkg::OP_ONE;
                    entry.num = {8'd0, r};
                    entry.den = tep_pkg::RAND_DIV;
                end
                default:
                    entry.op = tep_pkg::OP_LIN;
            endcase
        end
    end

endmodule

[design/tep_fifo.sv]
// small queue between front and back ends
// depends on tep_pkg
module tep_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tep_pkg::entry_t push_data,
    input  logic            pop,
    output tep_pkg::entry_t pop_data,
    output logic            full,
    output logic            empty
);

    tep_pkg::entry_t mem_reg [0:3];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;

    assign full     = count_reg == 3'd4;
    assign empty    = count_reg == 3'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 3'd1;
        else if (pop && !push)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[design/tep_back.sv]
// back end: pipelined restoring divider, cubic easing and output register
// depends on tep_pkg
module tep_back
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fifo_empty,
    input  tep_pkg::entry_t        fifo_data,
    output logic                   fifo_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FRACTION_BITS:0] progress,
    output logic                   error
);

    localparam int F  = FRACTION_BITS;
    localparam int DW = tep_pkg::DUR_W;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    typedef struct packed {
        logic [2:0]    op;
        logic [DW-1:0] rem;
        logic [F-1:0]  quo;
        logic [DW-1:0] den;
    } div_t;

    function automatic div_t div_step(input div_t s);
        div_t        o;
        logic [DW:0] t;
        logic [DW:0] d;
        begin
            o = s;
            t = {s.rem, 1'b0};
            d = t - {1'b0, s.den};
            if (t >= {1'b0, s.den})
            begin
                o.rem = d[DW-1:0];
                o.quo = {s.quo[F-2:0], 1'b1};
            end
            else
            begin
                o.rem = t[DW-1:0];
                o.quo = {s.quo[F-2:0], 1'b0};
            end
            return o;
        end
    endfunction

    logic ce;
    div_t dv_reg [0:F];
    logic [F:0] dv_vld_reg;

    assign ce       = !out_valid || !out_stall;
    assign fifo_pop = ce && !fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg <= '0;
        else if (ce)
            dv_vld_reg <= {dv_vld_reg[F-1:0], !fifo_empty};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dv_reg[0].op  <= fifo_data.op;
            dv_reg[0].rem <= fifo_data.num;
            dv_reg[0].quo <= '0;
            dv_reg[0].den <= fifo_data.den;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= F; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (ce)
                dv_reg[i] <= div_step(dv_reg[i-1]);
        end
    end

    // cubic stage 1: fold upper half, square
    logic [F-1:0]   p;
    logic           half;
    logic [F+1:0]   xw;
    logic [F:0]     x;
    logic [2*F+1:0] sq;

    assign p    = dv_reg[F].quo;
    assign half = p[F-1];
    assign xw   = ((F+2)'(1) << (F+1)) - {1'b0, p, 1'b0};
    assign x    = half ? xw[F:0] : {1'b0, p};
    assign sq   = x * x;

    logic [2:0]   m1_op_reg;
    logic [F-1:0] m1_p_reg;
    logic         m1_half_reg;
    logic [F:0]   m1_x_reg, m1_a_reg;
    logic         m1_vld_reg;

    // cubic stage 2: third power
    logic [2*F+1:0] cb;
    assign cb = m1_a_reg * m1_x_reg;

    logic [2:0]   m2_op_reg;
    logic [F-1:0] m2_p_reg;
    logic         m2_half_reg;
    logic [F:0]   m2_b_reg;
    logic         m2_vld_reg;

    logic [F:0] cubic;
    logic [F:0] res;
    logic [F:0] b4;

    assign b4    = {m2_b_reg[F-2:0], 2'b00};
    assign cubic = m2_half_reg ? (ONE - {1'b0, m2_b_reg[F:1]}) : b4;

    always_comb
    begin
        case (m2_op_reg)
            tep_pkg::OP_NEG:   res = '0;
            tep_pkg::OP_ONE:   res = ONE;
            tep_pkg::OP_ZERO:  res = '0;
            tep_pkg::OP_LIN:   res = {1'b0, m2_p_reg};
            tep_pkg::OP_CUBIC: res = cubic;
            default:           res = {1'b0, m2_p_reg};
        endcase
    end

    logic [F:0] progress_reg;
    logic       error_reg;
    logic       out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg    <= 1'b0;
            m2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            m1_vld_reg    <= dv_vld_reg[F];
            m2_vld_reg    <= m1_vld_reg;
            out_valid_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m1_op_reg    <= dv_reg[F].op;
            m1_p_reg     <= p;
            m1_half_reg  <= half;
            m1_x_reg     <= x;
            m1_a_reg     <= sq[2*F:F];
            m2_op_reg    <= m1_op_reg;
            m2_p_reg     <= m1_p_reg;
            m2_half_reg  <= m1_half_reg;
            m2_b_reg     <= cb[2*F:F];
            progress_reg <= res;
            error_reg    <= m2_op_reg == tep_pkg::OP_NEG;
        end
    end

    assign out_valid = out_valid_reg;
    assign progress  = progress_reg;
    assign error     = error_reg;

endmodule

[design/transition_easing_progress_core.sv]
// Transition easing core: takes one signed elapsed time per cycle while in_stall
// is low and returns the eased progress with FRACTION_BITS fraction bits.
// Throughput is one item per clock while out_stall does not hold the output;
// each item passes through the four-entry queue and the restoring divider
// that resolves one quotient bit per pipeline stage.
// depends on tep_pkg, tep_front, tep_fifo, tep_back
module transition_easing_progress_core
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [tep_pkg::DUR_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [tep_pkg::ELAP_W-1:0] elapsed_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [FRACTION_BITS:0]        progress,
    output logic                          error
);

    logic [tep_pkg::KIND_W-1:0] kind_reg;
    logic [tep_pkg::DUR_W-1:0]  duration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= tep_pkg::KIND_NONE;
            duration_reg <= tep_pkg::DURATION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tep_pkg::REG_KIND:     kind_reg <= cfg_data[tep_pkg::KIND_W-1:0];
                tep_pkg::REG_DURATION: duration_reg <= cfg_data;
                default:               kind_reg <= kind_reg;
            endcase
        end
    end

    tep_pkg::entry_t front_entry, q_entry;
    logic q_full, q_empty, q_pop, q_push;

    tep_front u_front
    (
        .elapsed_ms (elapsed_ms),
        .kind       (kind_reg),
        .duration   (duration_reg),
        .entry      (front_entry)
    );

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    tep_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_entry),
        .pop       (q_pop),
        .pop_data  (q_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    tep_back #(.FRACTION_BITS(FRACTION_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (q_empty),
        .fifo_data  (q_entry),
        .fifo_pop   (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .progress   (progress),
        .error      (error)
    );

endmodule

[design/tep_checker.sv]
// port-level checks for the easing core, bound to the top level
// depends on transition_easing_progress_core_assert.svh
`include "transition_easing_progress_core_assert.svh"
module tep_checker
#(
    parameter int FRACTION_BITS = 16
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [FRACTION_BITS:0] progress,
    input logic                   error
);

    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

    `TEP_ASSERT_NOW(a_err_zero, out_valid && error, progress == '0)
    `TEP_ASSERT_NOW(a_range, out_valid, progress <= ONE)
    `TEP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(progress) && $stable(error))

endmodule

bind transition_easing_progress_core tep_checker #(.FRACTION_BITS(FRACTION_BITS)) u_tep_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .progress  (progress),
    .error     (error)
);

[tb/sv/transition_easing_progress_core_test.sv]
`timescale 1ns / 100ps
// testbench for transition_easing_progress_core: random and directed elapsed times
// checked against an in-bench easing predictor; depends on tep_pkg and the core
module transition_easing_progress_core_test;

    localparam int FB = 16;
    localparam logic [63:0] ONE = 64'd1 << FB;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [FB:0] progress;
        logic        error;
    } ease_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [tep_pkg::DUR_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [tep_pkg::ELAP_W-1:0] elapsed_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [FB:0]           progress;
    logic                  error;

    transition_easing_progress_core #(.FRACTION_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .elapsed_ms(elapsed_ms), .out_valid(out_valid), .out_stall(out_stall),
        .progress(progress), .error(error)
    );

    logic [tep_pkg::KIND_W-1:0] cur_kind;
    logic [tep_pkg::DUR_W-1:0]  cur_dur;
    logic [31:0]       pending_times[$];
    ease_res_t         expected_progress[$];
    int                failures;
    int                cycles;
    bit                calm;        // no idling in the final part
    bit                hold_sender;
    bit                long_hold;
    int                send_gap;
    int                recv_gap;
    int                hold_count;

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return (a * b) >> FB;
    endfunction

    function automatic ease_res_t predict_ease(logic [31:0] e);
        ease_res_t r;
        logic [63:0] p, q, b, prog;
        logic [31:0] s;
        r.error = 1'b0;
        if (e[31])
        begin
            r.progress = '0;
            r.error = 1'b1;
            return r;
        end
        if (cur_kind == tep_pkg::KIND_NONE || cur_dur == 0 ||
            {32'd0, e} >= {40'd0, cur_dur})
        begin
            r.progress = ONE[FB:0];
            return r;
        end
        p = ({32'd0, e} * ONE) / {40'd0, cur_dur};
        case (cur_kind)
            tep_pkg::KIND_SLIDE, tep_pkg::KIND_WIPE:
            begin
                if (p < (ONE >> 1))
                    prog = 4 * qmul(qmul(p, p), p);
                else
                begin
                    q = 2 * ONE - 2 * p;
                    b = qmul(qmul(q, q), q);
                    prog = ONE - (b >> 1);
                end
            end
            tep_pkg::KIND_BLINK:
                prog = (2 * {32'd0, e} < {40'd0, cur_dur}) ? ONE : 64'd0;
            tep_pkg::KIND_RANDOM:
            begin
                s = (e ^ 32'h9e3779b9) * 32'd1103515245 + 32'd12345;
                prog = ({48'd0, s[15:0]} * ONE) / 64'd65535;
            end
            default: prog = p;
        endcase
        r.progress = prog[FB:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            elapsed_ms <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_progress.push_back(predict_ease(elapsed_ms));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (!hold_sender && pending_times.size() > 0)
                begin
                    in_valid <= 1'b1;
                    elapsed_ms <= pending_times.pop_front();
                    if (!calm && $urandom_range(0, 19) == 0)
                        send_gap <= $urandom_range(1, 9);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        ease_res_t x;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            hold_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_progress.size() == 0)
                begin
                    $display("%0t: unexpected transfer progress=%0d error=%0b",
                             $time, progress, error);
                    failures++;
                end
                else
                begin
                    x = expected_progress.pop_front();
                    if (x.progress !== progress)
                    begin
                        $display("%0t: progress expected %0d actual %0d",
                                 $time, x.progress, progress);
                        failures++;
                    end
                    if (x.error !== error)
                    begin
                        $display("%0t: error expected %0b actual %0b",
                                 $time, x.error, error);
                        failures++;
                    end
                end
            end
            if (long_hold && hold_count < 200)
            begin
                out_stall <= 1'b1;
                hold_count <= hold_count + 1;
            end
            else if (recv_gap > 0)
            begin
                out_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                recv_gap <= $urandom_range(0, 8);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        while (pending_times.size() > 0 || in_valid || expected_progress.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [tep_pkg::DUR_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tep_pkg::REG_KIND)
            cur_kind = val[tep_pkg::KIND_W-1:0];
        else
            cur_dur = val;
    endtask

    function automatic logic [31:0] pick_time(logic [tep_pkg::DUR_W-1:0] d);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom;
            2: return {8'd0, d};
            3: return {8'd0, d} + $urandom_range(0, 3);
            4: return (d > 0) ? ({8'd0, d} - 1) : 32'd0;
            5: return {8'd0, d} >> 1;
            6: return ({8'd0, d} >> 1) + $urandom_range(0, 1) - 0;
            default: return (d > 0) ? $urandom_range(0, d - 1) : 32'd0;
        endcase
    endfunction

    initial
    begin
        logic [tep_pkg::DUR_W-1:0] durs[6];
        int k;
        failures = 0;
        cycles = 0;
        calm = 0;
        hold_sender = 0;
        long_hold = 0;
        cur_kind = tep_pkg::KIND_NONE;
        cur_dur = tep_pkg::DURATION_RESET;
        cfg_we = 1'b0;
        cfg_index = tep_pkg::REG_KIND;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings then field extremes across kinds
        foreach (durs[i]) durs[i] = 0;
        pending_times = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd999,
                          32'd500, 32'd1000};
        drain();
        write_reg(tep_pkg::REG_DURATION, 24'd1000);
        for (int kd = 1; kd < 8; kd++)
        begin
            write_reg(tep_pkg::REG_KIND, kd[tep_pkg::KIND_W-1:0]);
            pending_times = '{32'd0, 32'd1, 32'd499, 32'd500, 32'd501, 32'd999,
                              32'd1000, 32'hffff_ffff, 32'h7fff_ffff, 32'h5555_aaaa};
            drain();
        end

        durs = '{24'd0, 24'd1, 24'd2, 24'd1000, 24'hffffff, 24'd0};
        for (int ph = 0; ph < 20; ph++)
        begin
            if (ph < 4) durs[5] = durs[ph];
            else if (ph % 5 == 0) durs[5] = 24'hffffff;
            else if (ph % 5 == 1) durs[5] = 24'd0;
            else durs[5] = $urandom_range(1, 70000);
            write_reg(tep_pkg::REG_DURATION, durs[5]);
            write_reg(tep_pkg::REG_KIND, ph[tep_pkg::KIND_W-1:0]);
            if (ph >= 17) calm = 1;
            for (k = 0; k < 55; k++)
                pending_times.push_back(pick_time(durs[5]));
            if (ph == 6)
                long_hold = 1;
            if (ph == 9)
            begin
                // sender pauses until everything sent so far has come back
                while (pending_times.size() > 25) @(posedge clk);
                hold_sender = 1;
                while (in_valid || expected_progress.size() > 0) @(posedge clk);
                hold_sender = 0;
            end
            drain();
            long_hold = 0;
        end

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
